// ===== rtl/bld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list deque package
// Command and status codes and the fixed beat field widths of the deque unit.
// ----------------------------------------------------------------------------
package bld_pkg;

    localparam int COMMAND_W = 3;
    localparam int VALUE_W   = 32;
    localparam int AMOUNT_W  = 11;
    localparam int STATUS_W  = 2;
    localparam int LENGTH_W  = 11;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_PUSH_FRONT   = 3'd0,
        CMD_PUSH_BACK    = 3'd1,
        CMD_REMOVE_FRONT = 3'd2,
        CMD_READ_AT      = 3'd3,
        CMD_KEEP_FIRST   = 3'd4,
        CMD_DROP_FIRST   = 3'd5
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2
    } status_t;

endpackage

// ===== rtl/bld_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list deque command channel
// Valid/ready channel that carries one command beat into the deque unit.
// ----------------------------------------------------------------------------
interface bld_cmd_if;

    logic                          valid;
    logic                          ready;
    logic [bld_pkg::COMMAND_W-1:0] command;
    logic [bld_pkg::VALUE_W-1:0]   value;
    logic [bld_pkg::AMOUNT_W-1:0]  amount;

    modport source (output valid, output command, output value, output amount, input ready);
    modport sink   (input valid, input command, input value, input amount, output ready);

endinterface

// ===== rtl/bld_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list deque response channel
// Valid/ready channel that carries one result beat out of the deque unit.
// ----------------------------------------------------------------------------
interface bld_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [bld_pkg::VALUE_W-1:0]  read_value;
    logic [bld_pkg::STATUS_W-1:0] status;
    logic [bld_pkg::LENGTH_W-1:0] length;
    logic                         is_empty_flag;

    modport source (output valid, output read_value, output status, output length,
                    output is_empty_flag, input ready);
    modport sink   (input valid, input read_value, input status, input length,
                    input is_empty_flag, output ready);

endinterface

// ===== rtl/bounded_list_deque_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded list deque unit
// A bounded ordered list of DEPTH elements held in a ring memory with a front
// pointer and an element count.
//
// Commands arrive as beats on the cmd channel and each produces exactly one
// result beat on the rsp channel, in order. Pushes, removes, keep and drop
// update the pointer and count at the accept edge, where pushes also write
// the ring memory, so their result is registered at that edge. An in-range
// read goes through the synchronous memory port into rd_data_reg and then the
// output register in S_READ. The unit accepts one command per cycle except
// after an in-range read: cmd.ready is low in S_READ while the read completes.
// The output register frees up in the same cycle its beat is taken, so a new
// command is taken while a result is being handed over. When rsp stalls, the
// result is held and cmd.ready stays low until it is taken.
// Reset empties the list and clears the front pointer; the memory contents
// are left as they are and are only read at positions written since.
// ----------------------------------------------------------------------------
module bounded_list_deque_unit #(
    parameter int DEPTH      = 1024,
    parameter int ELEM_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    bld_cmd_if.sink   cmd,
    bld_rsp_if.source rsp
);

    import bld_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > AMOUNT_W) ? CNT_W : AMOUNT_W;
    localparam int WIDE_W = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    state_t                state_reg;
    state_t                state_next;
    logic [PTR_W-1:0]      front_reg;
    logic [PTR_W-1:0]      front_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [ELEM_WIDTH-1:0] rd_data_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_W-1:0]    out_value_reg;
    logic [VALUE_W-1:0]    out_value_next;
    status_t               out_status_reg;
    status_t               out_status_next;
    logic [LENGTH_W-1:0]   out_length_reg;
    logic [LENGTH_W-1:0]   out_length_next;
    logic                  out_empty_reg;
    logic                  out_empty_next;

    logic                  accept;
    logic                  out_free;
    logic [CMP_W-1:0]      amt_c;
    logic [CMP_W-1:0]      cnt_c;
    logic [CMP_W-1:0]      cnt_next_c;
    logic                  full;
    logic                  amt_in_range;
    logic [PTR_W-1:0]      amt_pos;
    logic [PTR_W-1:0]      back_pos;
    logic [PTR_W-1:0]      prev_front;
    logic [WIDE_W-1:0]     value_wide;
    logic [WIDE_W-1:0]     rd_wide;
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic                  rd_en;
    status_t               status_now;

    function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] offset);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (PTR_W + 1)'(DEPTH))
        begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign amt_c        = CMP_W'(cmd.amount);
    assign cnt_c        = CMP_W'(count_reg);
    assign full         = (count_reg == CNT_W'(DEPTH));
    assign amt_in_range = (amt_c < cnt_c);
    assign amt_pos      = ring_pos(front_reg, amt_c[PTR_W-1:0]);
    assign back_pos     = ring_pos(front_reg, count_reg[PTR_W-1:0]);
    assign prev_front   = (front_reg == '0) ? PTR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign value_wide   = WIDE_W'(cmd.value);
    assign rd_wide      = WIDE_W'(rd_data_reg);
    assign cnt_next_c   = CMP_W'(count_next);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = back_pos;
        rd_en      = 1'b0;
        status_now = ST_OK;
        case (command_t'(cmd.command))
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_now = ST_FULL;
                end
                else
                begin
                    front_next = prev_front;
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = prev_front;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_now = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    wr_en      = 1'b1;
                end
            end
            CMD_REMOVE_FRONT:
            begin
                if (count_reg != '0)
                begin
                    front_next = ring_pos(front_reg, PTR_W'(1));
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_READ_AT:
            begin
                if (amt_in_range)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    status_now = ST_RANGE;
                end
            end
            CMD_KEEP_FIRST:
            begin
                if (amt_in_range)
                begin
                    count_next = amt_c[CNT_W-1:0];
                end
            end
            CMD_DROP_FIRST:
            begin
                if (amt_in_range)
                begin
                    front_next = amt_pos;
                    count_next = count_reg - amt_c[CNT_W-1:0];
                end
                else
                begin
                    count_next = '0;
                end
            end
            default:
            begin
                status_now = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_length_next = out_length_reg;
        out_empty_next  = out_empty_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (rd_en)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = status_now;
                        out_length_next = cnt_next_c[LENGTH_W-1:0];
                        out_empty_next  = (count_next == '0);
                    end
                end
            end
            S_READ:
            begin
                state_next      = S_IDLE;
                out_valid_next  = 1'b1;
                out_value_next  = rd_wide[VALUE_W-1:0];
                out_status_next = ST_OK;
                out_length_next = cnt_c[LENGTH_W-1:0];
                out_empty_next  = (count_reg == '0);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_length_reg <= '0;
            out_empty_reg  <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_length_reg <= out_length_next;
            out_empty_reg  <= out_empty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[wr_addr] <= value_wide[ELEM_WIDTH-1:0];
        end
        if (accept && rd_en)
        begin
            rd_data_reg <= mem[amt_pos];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_value    = out_value_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.length        = out_length_reg;
    assign rsp.is_empty_flag = out_empty_reg;

endmodule
